FILE: hdl/modular_exponentiation_assert.svh
// ----------------------------------------------------------------------------
// modular_exponentiation_assert
// assertion macros used by the checker module
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define MEXP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the following cycle
`define MEXP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: hdl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// types and constants shared by the modular exponentiation block
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int FIELD_WIDTH       = 32;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] base;
        logic [FIELD_WIDTH-1:0] exponent;
        logic [FIELD_WIDTH-1:0] modulus;
    } t_mexp_in;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] power_result;
        logic                   bad_modulus;
    } t_mexp_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_RED,
        S_RED_WR,
        S_CHECK,
        S_MACC,
        S_MACC_WR,
        S_SQR,
        S_SQR_WR,
        S_FINISH
    } t_state;

    // operand selection for the modular multiplier
    typedef enum logic [1:0] {
        MUL_SEL_RED,
        MUL_SEL_ACC,
        MUL_SEL_SQR
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     mul_start;
        t_mul_sel mul_sel;
        logic     mul_step;
        logic     wr_acc;
        logic     wr_base;
        logic     exp_shift;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic mod_zero;
        logic exp_zero;
        logic exp_lsb;
        logic mul_last;
    } t_dp_status;

endpackage

FILE: hdl/mexp_ctrl.sv
// ----------------------------------------------------------------------------
// mexp_ctrl
// sequencer for square-and-multiply and the result handshake
// ----------------------------------------------------------------------------
module mexp_ctrl
    import mexp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (i_in_valid) n_state = S_INIT;
            S_INIT:    n_state = i_status.mod_zero ? S_FINISH : S_RED;
            S_RED:     if (i_status.mul_last) n_state = S_RED_WR;
            S_RED_WR:  n_state = S_CHECK;
            S_CHECK: begin
                if (i_status.exp_zero) begin
                    n_state = S_FINISH;
                end else if (i_status.exp_lsb) begin
                    n_state = S_MACC;
                end else begin
                    n_state = S_SQR;
                end
            end
            S_MACC:    if (i_status.mul_last) n_state = S_MACC_WR;
            S_MACC_WR: n_state = S_SQR;
            S_SQR:     if (i_status.mul_last) n_state = S_SQR_WR;
            S_SQR_WR:  n_state = S_CHECK;
            S_FINISH:  if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_cmd.mul_sel = MUL_SEL_RED;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_INIT: begin
                o_cmd.mul_start = !i_status.mod_zero;
                o_cmd.mul_sel   = MUL_SEL_RED;
            end
            S_RED, S_MACC, S_SQR: begin
                o_cmd.mul_step = 1'b1;
            end
            S_RED_WR: begin
                o_cmd.wr_base = 1'b1;
            end
            S_CHECK: begin
                o_cmd.mul_start = !i_status.exp_zero;
                o_cmd.mul_sel   = i_status.exp_lsb ? MUL_SEL_ACC : MUL_SEL_SQR;
            end
            S_MACC_WR: begin
                o_cmd.wr_acc    = 1'b1;
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MUL_SEL_SQR;
            end
            S_SQR_WR: begin
                o_cmd.wr_base   = 1'b1;
                o_cmd.exp_shift = 1'b1;
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: hdl/mexp_dpath.sv
// ----------------------------------------------------------------------------
// mexp_dpath
// operand registers, bit-serial modular multiplier and result register
// ----------------------------------------------------------------------------
module mexp_dpath
    import mexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic       i_clk,
    input  t_mexp_in   i_in,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output t_mexp_out  o_out
);

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W);
    localparam logic [CW-1:0] CNT_TOP = CW'(W - 1);

    logic [W-1:0]  r_acc;
    logic [W-1:0]  r_base;
    logic [W-1:0]  r_exp;
    logic [W-1:0]  r_mod;
    logic [W-1:0]  r_prod;
    logic [W-1:0]  r_mcand;
    logic [W-1:0]  r_mplier;
    logic [CW-1:0] r_cnt;
    t_mexp_out     r_out;

    logic [W+FIELD_WIDTH-1:0] ext_base;
    logic [W+FIELD_WIDTH-1:0] ext_exp;
    logic [W+FIELD_WIDTH-1:0] ext_mod;
    logic [W+FIELD_WIDTH-1:0] ext_res;
    logic [W-1:0]             in_mod;
    logic [W-1:0]             one_w;
    logic [W+1:0]             sum;
    logic [W+1:0]             mod1;
    logic [W+1:0]             mod2;
    logic [W+1:0]             red;
    logic [W-1:0]             addend;

    // fit fields to the operand width, by zero extension or truncation
    assign ext_base = {{W{1'b0}}, i_in.base};
    assign ext_exp  = {{W{1'b0}}, i_in.exponent};
    assign ext_mod  = {{W{1'b0}}, i_in.modulus};
    assign ext_res  = {{FIELD_WIDTH{1'b0}}, r_acc};
    assign in_mod   = ext_mod[W-1:0];
    assign one_w    = {{(W-1){1'b0}}, 1'b1};

    // one step: 2*prod + (bit ? mcand : 0), reduced below the modulus
    assign addend = r_mplier[W-1] ? r_mcand : '0;
    assign sum    = {1'b0, r_prod, 1'b0} + {2'b00, addend};
    assign mod1   = {2'b00, r_mod};
    assign mod2   = {1'b0, r_mod, 1'b0};

    always_comb begin
        if (sum >= mod2) begin
            red = sum - mod2;
        end else if (sum >= mod1) begin
            red = sum - mod1;
        end else begin
            red = sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base <= ext_base[W-1:0];
            r_exp  <= ext_exp[W-1:0];
            r_mod  <= in_mod;
            r_acc  <= (in_mod == one_w) ? '0 : one_w;
        end
        if (i_cmd.mul_start) begin
            r_prod <= '0;
            r_cnt  <= CNT_TOP;
            case (i_cmd.mul_sel)
                MUL_SEL_RED: begin
                    r_mcand  <= one_w;
                    r_mplier <= r_base;
                end
                MUL_SEL_ACC: begin
                    r_mcand  <= r_acc;
                    r_mplier <= r_base;
                end
                MUL_SEL_SQR: begin
                    r_mcand  <= r_base;
                    r_mplier <= r_base;
                end
                default: begin
                    r_mcand  <= r_base;
                    r_mplier <= r_base;
                end
            endcase
        end else if (i_cmd.mul_step) begin
            r_prod   <= red[W-1:0];
            r_mplier <= {r_mplier[W-2:0], 1'b0};
            r_cnt    <= r_cnt - 1'b1;
        end
        if (i_cmd.wr_acc) begin
            r_acc <= r_prod;
        end
        if (i_cmd.wr_base) begin
            r_base <= r_prod;
        end
        if (i_cmd.exp_shift) begin
            r_exp <= {1'b0, r_exp[W-1:1]};
        end
        if (i_cmd.out_load) begin
            r_out.bad_modulus  <= (r_mod == '0);
            r_out.power_result <= (r_mod == '0) ? '0 : ext_res[FIELD_WIDTH-1:0];
        end
    end

    assign o_status.mod_zero = (r_mod == '0);
    assign o_status.exp_zero = (r_exp == '0);
    assign o_status.exp_lsb  = r_exp[0];
    assign o_status.mul_last = (r_cnt == '0);
    assign o_out             = r_out;

endmodule

FILE: hdl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// base ^ exponent mod modulus by right-to-left binary square-and-multiply
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_ready carry one transaction of base,
//   exponent and modulus; output channel: o_out_valid / i_out_ready carry
//   power_result and bad_modulus. one result per input transaction.
//   a zero modulus returns 0 with bad_modulus set.
//   the base is reduced first; then each exponent bit up to the highest
//   set one costs a square, plus a multiply before it when the bit is set;
//   a final state then loads the result register. the bit-serial modular
//   multiplier works one multiplier bit per cycle and is shared by
//   reduction, multiply and square.
//   one item is in flight at a time; a new transaction is taken once the
//   previous result sits in the output register, even while it waits.
//   a stalled receiver holds the result steady; the sequencer waits in its
//   final state until the output register is free.
//   reset (synchronous, active low) returns to idle and drops o_out_valid.
// ----------------------------------------------------------------------------
module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_mexp_in  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_mexp_out o_out
);

    // command and status between sequencer and datapath
    t_dp_cmd    cmd;
    t_dp_status status;

    // controller: state machine and output valid flag
    mexp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // datapath: operands, multiplier, result register
    mexp_dpath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_in     (i_in),
        .i_cmd    (cmd),
        .o_status (status),
        .o_out    (o_out)
    );

endmodule

FILE: hdl/mexp_checker.sv
// ----------------------------------------------------------------------------
// mexp_checker
// port-level checks for the modular exponentiation block
// ----------------------------------------------------------------------------
`include "modular_exponentiation_assert.svh"

module mexp_checker
    import mexp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_mexp_out o_out
);

    logic out_bad;

    assign out_bad = o_out_valid && o_out.bad_modulus;

    // an error result carries a zero value
    `MEXP_ASSERT_SAME(a_bad_is_zero, i_clk, i_rst_n, out_bad, o_out.power_result == '0)

    // busy straight after a transaction is taken
    `MEXP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // stalled result stays valid
    `MEXP_ASSERT_NEXT(a_out_hold_valid, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // stalled result keeps its payload
    `MEXP_ASSERT_NEXT(a_out_hold_data, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out))

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
